FILE: sv/tzr_pkg.sv
// Shared types and constants for the triangle depth-buffer rasterizer.
package tzr_pkg;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // quotient bits produced by the weight divider
  localparam int QB = 29;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRD,
    ST_VA,
    ST_VB,
    ST_VC,
    ST_VD,
    ST_BOX,
    ST_DSET,
    ST_PIX,
    ST_NUV,
    ST_TEST,
    ST_DIV,
    ST_WSET,
    ST_MAC,
    ST_MACF,
    ST_WB,
    ST_NEXT
  } state_t;

  typedef struct packed {
    logic          neg;
    logic          sat;
    logic [37:0]   rem;
    logic [QB-1:0] ml;
  } div_t;

endpackage

FILE: sv/triangle_zbuffer_rasterizer_core.sv
// Top level: triangle rasterizer with depth buffer, vertex and frame memories.
//
// One item is taken when start is high and busy is low; every item gives one
// result, shown for a single cycle on out_valid, which the receiver cannot hold
// off. A vertex load or pixel write is done without leaving idle; a pixel read
// passes through ST_PRD. A draw does vertex fetch and setup, then per pixel of
// the clamped box skips the pixel when rejected, else runs the bit-serial
// divider for the two weights (not for a degenerate triangle) and the shared
// multiplier that forms the twelve weight products. Each shaded pixel does a
// read-modify-write of the frame memory, one pixel at a time.
module triangle_zbuffer_rasterizer_core #(
  parameter int MAX_WIDTH    = 512,
  parameter int MAX_HEIGHT   = 512,
  parameter int VERTEX_SLOTS = 4096,
  parameter int CHANNELS     = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [11:0]        in_item_index,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [31:0] in_depth_in,
  input  logic [15:0]        in_color_r,
  input  logic [15:0]        in_color_g,
  input  logic [15:0]        in_color_b,
  input  logic [11:0]        in_vert_a,
  input  logic [11:0]        in_vert_b,
  input  logic [11:0]        in_vert_c,
  output logic               out_valid,
  output logic               out_status,
  output logic [18:0]        out_pixels_written,
  output logic [15:0]        out_r,
  output logic [15:0]        out_g,
  output logic [15:0]        out_b,
  output logic signed [31:0] out_depth
);
  import tzr_pkg::*;

  localparam int NCH    = (CHANNELS < 3) ? CHANNELS : 3;
  localparam int CWB    = 16 * NCH;
  localparam int VAW    = $clog2(VERTEX_SLOTS);
  localparam int VMW    = 64 + CWB;
  localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int FAW    = $clog2(FDEPTH);
  localparam int FMW    = 32 + CWB;
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);

  state_t state_r, state_nxt;

  logic [9:0]  width_r, height_r;
  logic [12:0] wact, hact;
  logic        accept, cfg_we;

  logic [VMW-1:0] vmem [VERTEX_SLOTS];
  logic [VMW-1:0] vrd_r;
  logic [VAW-1:0] vraddr;
  logic           vwe;
  logic [VMW-1:0] vwdata;

  logic [FMW-1:0] fmem [FDEPTH];
  logic [FMW-1:0] frd_r;
  logic [FAW-1:0] fraddr, in_faddr, pix_faddr;
  logic           fwe;
  logic [FMW-1:0] fwdata;

  logic [15:0]        chan [3];
  logic [CWB-1:0]     in_cols;
  logic [16:0]        slot_ext [4];
  logic               slot_ok [4];
  logic [VAW-1:0]     slot_addr [4];
  logic               pix_ok;
  logic               pix_ok_r;

  logic               vok_r [3];
  logic [VAW-1:0]     va_r [3];
  logic signed [15:0] vx_r [3];
  logic signed [15:0] vy_r [3];
  logic signed [31:0] vz_r [3];
  logic [15:0]        vc_r [3][3];
  logic [15:0]        rd_col [3];

  logic signed [15:0] mnx, mxx, mny, mxy;
  logic signed [16:0] bx0_r, bx1_r, by0_r, by1_r;
  logic signed [16:0] bx0, bx1, by0, by1;
  logic signed [16:0] v0x, v0y, v1x, v1y;
  logic signed [33:0] dp1_r, dp2_r;
  logic signed [36:0] dval;
  logic               dneg_r;
  logic [36:0]        dabs_r;
  logic               empty;

  logic [XW-1:0]      x_r, xmin_r, xmax_r;
  logic [YW-1:0]      y_r, ymax_r;
  logic signed [17:0] v2x, v2y;
  logic signed [34:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [36:0] nu_r, nv_r, nu, nv;
  logic signed [37:0] nsum;
  logic               in_tri, edge_px, dzero, skip_px;
  logic signed [16:0] xs, ys, wm3, hm3;

  div_t               dv_prep [2];
  logic               dneg2_r [2];
  logic               dsat_r [2];
  logic [37:0]        rem_r [2];
  logic [QB-1:0]      ml_r [2];
  logic [QB-1:0]      q_r [2];
  logic [37:0]        dv_r;
  logic [4:0]         dc_r;
  logic signed [29:0] wq [2];

  logic signed [30:0] wt_r [3];
  logic [1:0]         mi_r, mj_r, pj_r;
  logic               pv_r;
  logic signed [63:0] prod_r;
  logic signed [32:0] opv;
  logic signed [65:0] acc_r [4];
  logic signed [65:0] dq;
  logic signed [31:0] dep;
  logic [15:0]        wcol [3];
  logic [CWB-1:0]     wcols;
  logic               upd;
  logic [18:0]        count_r;
  logic               last_px, mac_last;

  logic               ov_r, os_r;
  logic [18:0]        opw_r;
  logic [15:0]        or_r, og_r, ob_r;
  logic signed [31:0] od_r;

  function automatic div_t div_prep(input logic signed [36:0] n, input logic [36:0] d);
    logic signed [57:0] num;
    logic signed [57:0] dvx;
    logic [57:0]        mag;
    div_t               r;
    num = (58'(n) <<< 17) + $signed(58'(d));
    dvx = $signed(58'(d) << 1);
    r.neg = num[57];
    mag = r.neg ? 58'(-num + dvx - 58'sd1) : 58'(num);
    r.sat = (mag >> QB) >= 58'(dvx);
    r.rem = 38'(mag >> QB);
    r.ml  = mag[QB-1:0];
    return r;
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_r) : 32'(width_r);

  always_comb begin
    if (width_r == 10'd0) wact = 13'd1;
    else if (13'(width_r) > 13'(MAX_WIDTH)) wact = 13'(MAX_WIDTH);
    else wact = 13'(width_r);
    if (height_r == 10'd0) hact = 13'd1;
    else if (13'(height_r) > 13'(MAX_HEIGHT)) hact = 13'(MAX_HEIGHT);
    else hact = 13'(height_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 10'd512;
      height_r <= 10'd512;
    end else if (cfg_we) begin
      if (paddr[2] == REG_WIDTH) width_r <= pwdata[9:0];
      else height_r <= pwdata[9:0];
    end
  end

  // input decode
  always_comb begin
    chan[0] = in_color_r;
    chan[1] = in_color_g;
    chan[2] = in_color_b;
    in_cols = '0;
    for (int k = 0; k < NCH; k++) in_cols[16*k +: 16] = chan[k];
    slot_ext[0] = 17'(in_item_index);
    slot_ext[1] = 17'(in_vert_a);
    slot_ext[2] = 17'(in_vert_b);
    slot_ext[3] = 17'(in_vert_c);
    for (int k = 0; k < 4; k++) begin
      slot_ok[k]   = slot_ext[k] < 17'(VERTEX_SLOTS);
      slot_addr[k] = slot_ext[k][VAW-1:0];
    end
    pix_ok = !in_pos_x[15] && !in_pos_y[15] &&
             (17'(in_pos_x) < 17'(wact)) && (17'(in_pos_y) < 17'(hact));
    in_faddr  = FAW'(32'(in_pos_y[14:0]) * 32'(MAX_WIDTH) + 32'(in_pos_x[14:0]));
    pix_faddr = FAW'(32'(y_r) * 32'(MAX_WIDTH) + 32'(x_r));
  end

  // vertex memory
  always_comb begin
    unique case (state_r)
      ST_VA:   vraddr = va_r[0];
      ST_VB:   vraddr = va_r[1];
      default: vraddr = va_r[2];
    endcase
    vwe    = accept && (in_mode == MODE_LOAD) && slot_ok[0];
    vwdata = {in_pos_x, in_pos_y, in_depth_in, in_cols};
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[slot_addr[0]] <= vwdata;
    vrd_r <= vmem[vraddr];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) rd_col[k] = '0;
    for (int k = 0; k < NCH; k++) rd_col[k] = frd_r[16*k +: 16];
  end

  // frame memory
  always_comb begin
    fraddr = (state_r == ST_IDLE) ? in_faddr : pix_faddr;
    if (state_r == ST_WB) begin
      fwe    = upd;
      fwdata = {dep, wcols};
    end else begin
      fwe    = accept && (in_mode == MODE_WRITE) && pix_ok;
      fwdata = {in_depth_in, in_cols};
    end
  end

  always_ff @(posedge clk) begin
    if (fwe) fmem[fraddr] <= fwdata;
    frd_r <= fmem[fraddr];
  end

  // setup arithmetic
  always_comb begin
    mnx = vx_r[0]; mxx = vx_r[0]; mny = vy_r[0]; mxy = vy_r[0];
    for (int i = 1; i < 3; i++) begin
      if (vx_r[i] < mnx) mnx = vx_r[i];
      if (vx_r[i] > mxx) mxx = vx_r[i];
      if (vy_r[i] < mny) mny = vy_r[i];
      if (vy_r[i] > mxy) mxy = vy_r[i];
    end
    bx0 = 17'(mnx) >>> 4;
    by0 = 17'(mny) >>> 4;
    bx1 = (17'(mxx) + 17'sd15) >>> 4;
    by1 = (17'(mxy) + 17'sd15) >>> 4;
    if (bx0 < 0) bx0 = '0;
    if (by0 < 0) by0 = '0;
    if (bx1 > $signed(17'(wact)) - 17'sd1) bx1 = $signed(17'(wact)) - 17'sd1;
    if (by1 > $signed(17'(hact)) - 17'sd1) by1 = $signed(17'(hact)) - 17'sd1;
    v0x = 17'(vx_r[2]) - 17'(vx_r[0]);
    v0y = 17'(vy_r[2]) - 17'(vy_r[0]);
    v1x = 17'(vx_r[1]) - 17'(vx_r[0]);
    v1y = 17'(vy_r[1]) - 17'(vy_r[0]);
    dval  = 37'(dp1_r) - 37'(dp2_r);
    empty = (bx1_r < bx0_r) || (by1_r < by0_r);
  end

  // per-pixel arithmetic
  always_comb begin
    v2x = $signed(18'({x_r, 4'b0000})) - 18'(vx_r[0]);
    v2y = $signed(18'({y_r, 4'b0000})) - 18'(vy_r[0]);
    nu  = 37'(pa_r) - 37'(pb_r);
    nv  = 37'(pc_r) - 37'(pd_r);
    if (dneg_r) begin
      nu = -nu;
      nv = -nv;
    end
    nsum   = 38'(nu_r) + 38'(nv_r);
    in_tri = !nu_r[36] && !nv_r[36] && (nsum <= $signed(38'(dabs_r)));
    xs  = $signed(17'(x_r));
    ys  = $signed(17'(y_r));
    wm3 = $signed(17'(wact)) - 17'sd3;
    hm3 = $signed(17'(hact)) - 17'sd3;
    edge_px = (xs < 17'sd2) || (xs > wm3) || (ys < 17'sd2) || (ys > hm3);
    dzero   = (dabs_r == '0);
    skip_px = !dzero && !edge_px && !in_tri;
    dv_prep[0] = div_prep(nv_r, dabs_r);
    dv_prep[1] = div_prep(nu_r, dabs_r);
    for (int k = 0; k < 2; k++) begin
      if (dsat_r[k] || (q_r[k] > QB'(1 << 28))) wq[k] = 30'sd268435456;
      else wq[k] = $signed(30'(q_r[k]));
      if (dneg2_r[k]) wq[k] = -wq[k];
    end
    if (mj_r == 2'd0) opv = 33'(vz_r[mi_r]);
    else opv = $signed(33'(vc_r[mi_r][mj_r - 2'd1]));
    mac_last = (mi_r == 2'd2) && (mj_r == 2'd3);
    last_px  = (x_r == xmax_r) && (y_r == ymax_r);
  end

  // depth and color resolve
  always_comb begin
    dq = (acc_r[0] + 66'sd32768) >>> 16;
    if (dq > 66'sd2147483647) dep = 32'sh7fffffff;
    else if (dq < -66'sd2147483648) dep = 32'sh80000000;
    else dep = dq[31:0];
    wcols = '0;
    for (int k = 0; k < 3; k++) begin
      dq = (acc_r[k+1] + 66'sd32768) >>> 16;
      if (dq < 0) wcol[k] = 16'd0;
      else if (dq > 66'sd65535) wcol[k] = 16'hffff;
      else wcol[k] = dq[15:0];
    end
    for (int k = 0; k < NCH; k++) wcols[16*k +: 16] = wcol[k];
    upd = dep > $signed(frd_r[FMW-1 -: 32]);
  end

  // control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_READ) state_nxt = ST_PRD;
          else if (in_mode == MODE_DRAW) state_nxt = ST_VA;
        end
      end
      ST_PRD:  state_nxt = ST_IDLE;
      ST_VA:   state_nxt = ST_VB;
      ST_VB:   state_nxt = ST_VC;
      ST_VC:   state_nxt = ST_VD;
      ST_VD:   state_nxt = ST_BOX;
      ST_BOX:  state_nxt = ST_DSET;
      ST_DSET: state_nxt = empty ? ST_IDLE : ST_PIX;
      ST_PIX:  state_nxt = ST_NUV;
      ST_NUV:  state_nxt = ST_TEST;
      ST_TEST: begin
        if (dzero) state_nxt = ST_MAC;
        else if (skip_px) state_nxt = ST_NEXT;
        else state_nxt = ST_DIV;
      end
      ST_DIV:  state_nxt = (dc_r == 5'(QB - 1)) ? ST_WSET : ST_DIV;
      ST_WSET: state_nxt = ST_MAC;
      ST_MAC:  state_nxt = mac_last ? ST_MACF : ST_MAC;
      ST_MACF: state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_NEXT;
      ST_NEXT: state_nxt = last_px ? ST_IDLE : ST_PIX;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    pv_r <= 1'b0;
    if (pv_r) acc_r[pj_r] <= acc_r[pj_r] + 66'(prod_r);
    case (state_r)
      ST_IDLE: begin
        pix_ok_r <= pix_ok;
        for (int k = 0; k < 3; k++) begin
          vok_r[k] <= slot_ok[k+1];
          va_r[k]  <= slot_addr[k+1];
        end
      end
      ST_VB, ST_VC, ST_VD: begin
        for (int i = 0; i < 3; i++) begin
          if ((i == 0 && state_r == ST_VB) || (i == 1 && state_r == ST_VC) ||
              (i == 2 && state_r == ST_VD)) begin
            if (vok_r[i]) begin
              vx_r[i] <= vrd_r[VMW-1 -: 16];
              vy_r[i] <= vrd_r[VMW-17 -: 16];
              vz_r[i] <= vrd_r[VMW-33 -: 32];
              for (int k = 0; k < 3; k++) vc_r[i][k] <= '0;
              for (int k = 0; k < NCH; k++) vc_r[i][k] <= vrd_r[16*k +: 16];
            end else begin
              vx_r[i] <= '0;
              vy_r[i] <= '0;
              vz_r[i] <= '0;
              for (int k = 0; k < 3; k++) vc_r[i][k] <= '0;
            end
          end
        end
      end
      ST_BOX: begin
        bx0_r <= bx0; bx1_r <= bx1; by0_r <= by0; by1_r <= by1;
        dp1_r <= v0x * v1y;
        dp2_r <= v0y * v1x;
      end
      ST_DSET: begin
        dneg_r  <= dval[36];
        dabs_r  <= dval[36] ? 37'(-dval) : 37'(dval);
        xmin_r  <= bx0_r[XW-1:0];
        xmax_r  <= bx1_r[XW-1:0];
        ymax_r  <= by1_r[YW-1:0];
        x_r     <= bx0_r[XW-1:0];
        y_r     <= by0_r[YW-1:0];
        count_r <= '0;
      end
      ST_PIX: begin
        pa_r <= v2x * v1y;
        pb_r <= v2y * v1x;
        pc_r <= v0x * v2y;
        pd_r <= v0y * v2x;
      end
      ST_NUV: begin
        nu_r <= nu;
        nv_r <= nv;
      end
      ST_TEST: begin
        for (int k = 0; k < 2; k++) begin
          dneg2_r[k] <= dv_prep[k].neg;
          dsat_r[k]  <= dv_prep[k].sat;
          rem_r[k]   <= dv_prep[k].rem;
          ml_r[k]    <= dv_prep[k].ml;
          q_r[k]     <= '0;
        end
        dv_r  <= 38'(dabs_r) << 1;
        dc_r  <= '0;
        wt_r[0] <= 31'sd65536;
        wt_r[1] <= '0;
        wt_r[2] <= '0;
        mi_r  <= '0;
        mj_r  <= '0;
        for (int j = 0; j < 4; j++) acc_r[j] <= '0;
      end
      ST_DIV: begin
        for (int k = 0; k < 2; k++) begin
          if ({rem_r[k][36:0], ml_r[k][QB-1]} >= dv_r) begin
            rem_r[k] <= {rem_r[k][36:0], ml_r[k][QB-1]} - dv_r;
            q_r[k]   <= {q_r[k][QB-2:0], 1'b1};
          end else begin
            rem_r[k] <= {rem_r[k][36:0], ml_r[k][QB-1]};
            q_r[k]   <= {q_r[k][QB-2:0], 1'b0};
          end
          ml_r[k] <= {ml_r[k][QB-2:0], 1'b0};
        end
        dc_r <= dc_r + 5'd1;
      end
      ST_WSET: begin
        wt_r[0] <= 31'sd65536 - 31'(wq[0]) - 31'(wq[1]);
        wt_r[1] <= 31'(wq[0]);
        wt_r[2] <= 31'(wq[1]);
      end
      ST_MAC: begin
        prod_r <= wt_r[mi_r] * opv;
        pj_r   <= mj_r;
        pv_r   <= 1'b1;
        if (mi_r == 2'd2) begin
          mi_r <= '0;
          mj_r <= mj_r + 2'd1;
        end else begin
          mi_r <= mi_r + 2'd1;
        end
      end
      ST_WB: begin
        if (upd) count_r <= count_r + 19'd1;
      end
      ST_NEXT: begin
        if (x_r == xmax_r) begin
          x_r <= xmin_r;
          y_r <= y_r + YW'(1);
        end else begin
          x_r <= x_r + XW'(1);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= (accept && (in_mode == MODE_LOAD || in_mode == MODE_WRITE)) ||
                 (state_r == ST_PRD) || (state_r == ST_DSET && empty) ||
                 (state_r == ST_NEXT && last_px);
  end

  always_ff @(posedge clk) begin
    os_r  <= 1'b0;
    opw_r <= '0;
    or_r  <= '0;
    og_r  <= '0;
    ob_r  <= '0;
    od_r  <= '0;
    if (state_r == ST_PRD && pix_ok_r) begin
      or_r <= rd_col[0];
      og_r <= rd_col[1];
      ob_r <= rd_col[2];
      od_r <= frd_r[FMW-1 -: 32];
    end
    if (state_r == ST_DSET) os_r <= empty;
    if (state_r == ST_NEXT) opw_r <= count_r;
  end

  assign out_valid          = ov_r;
  assign out_status         = os_r;
  assign out_pixels_written = opw_r;
  assign out_r              = or_r;
  assign out_g              = og_r;
  assign out_b              = ob_r;
  assign out_depth          = od_r;

endmodule
